// ===== hdl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the projection-profile character segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SIZE_W  = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } size_t;

  typedef struct packed {
    logic               frame_end;
    logic [COORD_W-1:0] bottom_row;
    logic [COORD_W-1:0] top_row;
    logic [SIZE_W-1:0]  segment_width;
    logic [COORD_W-1:0] start_column;
  } result_t;

  // A size of zero acts as one, and anything above the maximum as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pcs_seg.sv =====
// ----------------------------------------------------------------------------
// pcs_seg
// Per-pixel column tracking and segment bookkeeping; one pixel per step.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_seg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            pix,
  input  wire pcs_pkg::size_t        size,
  output logic                       res_valid,
  output pcs_pkg::result_t           res
);
  import pcs_pkg::*;

  logic [COORD_W-1:0] row_count,  row_count_next;
  logic [COORD_W-1:0] column_count, column_count_next;
  logic               column_inked, column_inked_next;
  logic               run_open, run_open_next;
  logic [COORD_W-1:0] run_start, run_start_next;
  logic               run_has_black, run_has_black_next;
  logic [COORD_W-1:0] run_min_row, run_min_row_next;
  logic [COORD_W-1:0] run_max_row, run_max_row_next;

  logic              col_end;
  logic              last_col;
  logic [SIZE_W-1:0] span;

  always_comb begin
    run_open_next      = run_open;
    run_start_next     = run_start;
    run_has_black_next = run_has_black;
    run_min_row_next   = run_min_row;
    run_max_row_next   = run_max_row;
    column_inked_next  = column_inked;

    if (pix != PIX_WHITE) begin
      column_inked_next = 1'b1;
      if (!run_open) begin
        run_open_next      = 1'b1;
        run_start_next     = column_count;
        run_has_black_next = 1'b0;
        run_min_row_next   = '1;
        run_max_row_next   = '0;
      end
      if (pix == PIX_BLACK) begin
        if (!run_has_black_next || row_count < run_min_row_next) begin
          run_min_row_next = row_count;
        end
        if (!run_has_black_next || row_count > run_max_row_next) begin
          run_max_row_next = row_count;
        end
        run_has_black_next = 1'b1;
      end
    end

    col_end  = ({1'b0, row_count} + SIZE_W'(1)) >= size.height;
    last_col = ({1'b0, column_count} + SIZE_W'(1)) >= size.width;

    // A white column closes the run before it; otherwise the image edge does.
    span = {1'b0, column_count} - {1'b0, run_start_next};
    if (column_inked_next) span = span + SIZE_W'(1);

    res_valid = col_end && run_open_next && (!column_inked_next || last_col);

    res.start_column  = run_start_next;
    res.segment_width = span;
    res.top_row       = run_has_black_next ? run_min_row_next : '0;
    res.bottom_row    = run_has_black_next ? run_max_row_next : '0;
    res.frame_end     = column_inked_next;

    if (res_valid) run_open_next = 1'b0;

    row_count_next    = row_count + COORD_W'(1);
    column_count_next = column_count;
    if (col_end) begin
      row_count_next    = '0;
      column_inked_next = 1'b0;
      column_count_next = last_col ? '0 : column_count + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      column_count  <= '0;
      column_inked  <= 1'b0;
      run_open      <= 1'b0;
      run_start     <= '0;
      run_has_black <= 1'b0;
      run_min_row   <= '1;
      run_max_row   <= '0;
    end else if (step) begin
      row_count     <= row_count_next;
      column_count  <= column_count_next;
      column_inked  <= column_inked_next;
      run_open      <= run_open_next;
      run_start     <= run_start_next;
      run_has_black <= run_has_black_next;
      run_min_row   <= run_min_row_next;
      run_max_row   <= run_max_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/projection_char_segmenter.sv =====
// ----------------------------------------------------------------------------
// projection_char_segmenter
// Splits a binarized text line, streamed column by column, into characters.
// ----------------------------------------------------------------------------
// A closing pixel is held in the pixel register, its segment in the result register.
// Throughput: one pixel per cycle unless the output stalls; the two registers
// frame the single step of segment logic, so the output can stall one deep.
// Reset: synchronous; counters and run state clear, sizes return to 640x480.
`default_nettype none

module projection_char_segmenter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // pixel_value[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // start_column[11:0], segment_width[24:12], top_row[36:25],
  // bottom_row[48:37], zero fill[55:49]
  output logic [55:0]      m_tdata,
  output logic             m_tlast,   // frame_end
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pcs_pkg::*;

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  reg_index_t        reg_sel;
  size_t             size;

  logic       pix_valid;
  logic [7:0] pix;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, image_height};
      default:          prdata = '0;
    endcase
  end

  assign size.width  = clamp_size(image_width, SIZE_W'(MAX_WIDTH));
  assign size.height = clamp_size(image_height, SIZE_W'(MAX_HEIGHT));

  // The pixel register advances whenever the result register can take a value.
  assign out_free = !m_tvalid || m_tready;
  assign step     = pix_valid && out_free;
  assign s_tready = !rst && (!pix_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      pix_valid <= 1'b1;
    end else if (step) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix <= s_tdata;
    end
  end

  pcs_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pix       (pix),
    .size      (size),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.bottom_row, out_res.top_row,
                    out_res.segment_width, out_res.start_column};
  assign m_tlast = out_res.frame_end;

endmodule

`default_nettype wire

// ===== hdl/pcs_checker.sv =====
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tlast
);

  // A stalled segment must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Every segment holds at least one inked column.
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[24:12] != 13'd0)
    else $error("segment of zero width");

  // The top row never lies below the bottom row.
  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[36:25] <= m_tdata[48:37])
    else $error("top row below bottom row");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // No pixel transaction completes while reset is held.
  a_reset_no_take: assert property (@(posedge clk)
    rst |-> !(s_tvalid && s_tready))
    else $error("pixel taken during reset");

endmodule

bind projection_char_segmenter pcs_checker u_pcs_checker (.*);

`default_nettype wire

// ===== bench/pcs_checker.sv =====
// ----------------------------------------------------------------------------
// pcs_scoreboard
// Watches the pixel, segment and register channels of the character
// segmenter. It keeps its own copy of the segmentation state, predicts the
// segment for every accepted pixel that closes one, and compares each
// segment transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pcs_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel_value[7:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  // start_column[11:0], segment_width[24:12], top_row[36:25],
  // bottom_row[48:37], zero fill[55:49]
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          segments_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;

  int unsigned row_pos;
  int unsigned col_pos;
  logic        col_inked;
  logic        seg_open;
  int unsigned seg_start;
  logic        seg_black;
  int unsigned seg_top;
  int unsigned seg_bottom;

  result_t segment_q[$];

  task automatic clear_state();
    cfg_width  = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    row_pos    = 0;
    col_pos    = 0;
    col_inked  = 1'b0;
    seg_open   = 1'b0;
    seg_start  = 0;
    seg_black  = 1'b0;
    seg_top    = 12'hFFF;
    seg_bottom = 0;
  endtask

  // Advances the segmentation state by one pixel and queues the segment that
  // the pixel closes, if any.
  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    logic        last_col;
    result_t     seg;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
    if (pix != PIX_WHITE) begin
      col_inked = 1'b1;
      if (!seg_open) begin
        seg_open   = 1'b1;
        seg_start  = col_pos;
        seg_black  = 1'b0;
        seg_top    = 12'hFFF;
        seg_bottom = 0;
      end
      if (pix == PIX_BLACK) begin
        if (!seg_black || row_pos < seg_top) seg_top = row_pos;
        if (!seg_black || row_pos > seg_bottom) seg_bottom = row_pos;
        seg_black = 1'b1;
      end
    end
    // A shrunken height or width takes effect at once: the counters wrap as
    // soon as they have reached or passed the new last row or column.
    if (row_pos + 1 >= h) begin
      last_col = (col_pos + 1 >= w);
      if (seg_open && (!col_inked || last_col)) begin
        // A white column closes the run before it; an inked last column
        // closes the run at the image edge and belongs to it.
        seg.start_column  = COORD_W'(seg_start);
        seg.segment_width = SIZE_W'(col_pos - seg_start + (col_inked ? 1 : 0));
        seg.top_row       = seg_black ? COORD_W'(seg_top) : '0;
        seg.bottom_row    = seg_black ? COORD_W'(seg_bottom) : '0;
        seg.frame_end     = col_inked;
        segment_q = {segment_q, seg};
        seg_open = 1'b0;
      end
      row_pos   = 0;
      col_inked = 1'b0;
      col_pos   = last_col ? 0 : col_pos + 1;
    end else begin
      row_pos++;
    end
  endtask

  task automatic compare_segment();
    result_t want;
    result_t got;
    got.start_column  = m_tdata[11:0];
    got.segment_width = m_tdata[24:12];
    got.top_row       = m_tdata[36:25];
    got.bottom_row    = m_tdata[48:37];
    got.frame_end     = m_tlast;
    if (segment_q.size() == 0) begin
      $error("segment transaction with no segment expected: start_column %0d",
             got.start_column);
      errors++;
    end else begin
      want = segment_q.pop_front();
      segments_checked++;
      if (got.start_column != want.start_column) begin
        $error("start_column: expected %0d, got %0d", want.start_column, got.start_column);
        errors++;
      end
      if (got.segment_width != want.segment_width) begin
        $error("segment_width: expected %0d, got %0d", want.segment_width,
               got.segment_width);
        errors++;
      end
      if (got.top_row != want.top_row) begin
        $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
        errors++;
      end
      if (got.bottom_row != want.bottom_row) begin
        $error("bottom_row: expected %0d, got %0d", want.bottom_row, got.bottom_row);
        errors++;
      end
      if (got.frame_end != want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    end
  endtask

  task automatic watch_registers();
    logic [31:0] want;
    if (psel && penable && pready) begin
      case (reg_index_t'(paddr[2]))
        REG_IMAGE_WIDTH: begin
          want = 32'(cfg_width);
          if (pwrite) cfg_width = pwdata[SIZE_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          want = 32'(cfg_height);
          if (pwrite) cfg_height = pwdata[SIZE_W-1:0];
        end
        default: want = '0;
      endcase
      if (!pwrite && prdata !== want) begin
        $error("register %0d read: expected %0d, got %0d", paddr[2], want, prdata);
        errors++;
      end
    end
  endtask

  initial begin
    errors           = 0;
    pending          = 0;
    segments_checked = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      segment_q.delete();
    end else begin
      watch_registers();
      if (s_tvalid && s_tready) take_pixel(s_tdata);
      if (m_tvalid && m_tready) compare_segment();
    end
    pending = segment_q.size();
  end

endmodule

// ===== bench/tb_projection_char_segmenter.sv =====
// ----------------------------------------------------------------------------
// tb_projection_char_segmenter
// Drives the character segmenter with a short hand-built text line and then
// with random column-major images over a range of image sizes, including
// out-of-range sizes and size changes part-way through a frame. Both stream
// sides idle at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_projection_char_segmenter;

  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam int HOLD_CYCLES = 200;

  typedef enum logic [1:0] {
    COL_WHITE,
    COL_INKED,
    COL_NOISE
  } column_kind_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int segments_checked;
  int pixels_sent;

  logic quiet;
  logic hold_req;

  projection_char_segmenter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pcs_scoreboard u_scoreboard (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .errors           (errors),
    .pending          (pending),
    .segments_checked (segments_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d segments still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Segment receiver. A hold-off request keeps tready low for a long stretch
  // so that the block fills up and stops taking pixels.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic reg_access(input reg_index_t idx, input logic wr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] value);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Waits until every predicted segment has arrived, then lets the pipeline
  // empty of pixels that close nothing before the sizes may change.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned width, input int unsigned height,
                           input int count, input logic no_idle, input logic hold);
    int unsigned  eff_h;
    int unsigned  row;
    int           r;
    column_kind_t kind;
    logic [7:0]   pix;
    reg_access(REG_IMAGE_WIDTH, 1'b1, width);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, height);
    reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
    reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);
    quiet = no_idle;
    eff_h = (height[12:0] == 0) ? 1 : ((height[12:0] > MAX_HEIGHT) ? MAX_HEIGHT : height[12:0]);
    row   = 0;
    kind  = COL_WHITE;
    for (int i = 0; i < count; i++) begin
      if (hold && i == count / 4) hold_req = 1'b1;
      // The row count here only shapes the stimulus into columns; after a
      // size change mid-frame it may be out of step with the block.
      if (row == 0) begin
        r = $urandom_range(0, 99);
        kind = (r < 40) ? COL_WHITE : ((r < 90) ? COL_INKED : COL_NOISE);
      end
      case (kind)
        COL_WHITE: pix = PIX_WHITE;
        COL_INKED: begin
          r = $urandom_range(0, 3);
          pix = (r < 2) ? PIX_WHITE : ((r == 2) ? PIX_BLACK : 8'($urandom_range(1, 254)));
        end
        default: pix = 8'($urandom_range(0, 255));
      endcase
      push_pixel(pix);
      row = (row + 1 >= eff_h) ? 0 : row + 1;
    end
    drain();
    quiet = 1'b0;
  endtask

  // Two frames of a 4 x 3 image. The first has a run touching column 0 with
  // black on the top and bottom rows, closed by a white column, then a run in
  // the last column closed at the image edge. The second has a run with grey
  // pixels only and ends on a white last column.
  logic [7:0] text_line [24] = '{
    8'h00, 8'hFF, 8'h00,  8'hFF, 8'h80, 8'hFF,  8'hFF, 8'hFF, 8'hFF,  8'hFF, 8'h00, 8'hFF,
    8'hFF, 8'hFF, 8'hFF,  8'hFE, 8'h01, 8'hFF,  8'hFF, 8'hFF, 8'hFF,  8'hFF, 8'hFF, 8'hFF
  };

  initial begin
    rst         = 1'b1;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    pixels_sent = 0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes read back before anything is written.
    reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
    reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);

    reg_access(REG_IMAGE_WIDTH, 1'b1, 32'd4);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 32'd3);
    foreach (text_line[i]) push_pixel(text_line[i]);
    drain();

    // Sizes of zero act as 1 x 1; oversized values saturate at the maximum.
    run_phase(0, 0, 60, 1'b0, 1'b0);
    run_phase(1, 6, 90, 1'b0, 1'b0);
    run_phase(8191, 1, 150, 1'b1, 1'b0);
    run_phase(12, 5, 200, 1'b0, 1'b0);
    run_phase(5, 4096, 150, 1'b0, 1'b0);
    run_phase(7, 3, 150, 1'b0, 1'b0);
    run_phase(4096, 8191, 100, 1'b0, 1'b0);
    run_phase(20, 2, 150, 1'b0, 1'b1);
    run_phase(3, 8, 150, 1'b0, 1'b0);
    repeat (8) @(posedge clk);

    $display("Sent %0d pixels over ten image sizes, from 1 x 1 to 4096 rows,", pixels_sent);
    $display("with size changes mid-frame; %0d segments checked.", segments_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
